// ----- hw/rtl/srtoi_pkg.sv -----
// ----------------------------------------------------------------------------
// srtoi_pkg
// Shared types and constants for the streaming string-to-integer parser.
// ----------------------------------------------------------------------------
package srtoi_pkg;

  // field widths
  localparam int VALUE_WIDTH    = 64;
  localparam int CONSUMED_WIDTH = 16;
  localparam int CHAR_WIDTH     = 8;
  localparam int BASE_WIDTH     = 5;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 5;

  // default width of the saturating character counter
  localparam int COUNT_WIDTH_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_BASE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_MODE = 2'd1;

  // radix values
  localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 5'd8;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 5'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 5'd16;

  // classification of one character
  typedef struct packed {
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic       dig_ok;
    logic [3:0] dig;
  } char_class_t;

  // result of one step
  typedef struct packed {
    logic                      emit;
    logic [VALUE_WIDTH-1:0]    value;
    logic [CONSUMED_WIDTH-1:0] consumed;
    logic                      found;
  } result_t;

endpackage

// ----- hw/rtl/string_to_integer_parser.sv -----
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming text-to-integer parser: one character per word in, one result
// word out for each character that ends a number.
// ----------------------------------------------------------------------------
// Takes one character every cycle when the output side keeps up. A character
// passes an input register; once the result slot can take a word, the parse
// state and the result register are updated, and the result word is offered
// from the result register. The cycle time is set by the accumulator step, one
// 64-bit by 5-bit multiply-add. Radix and sign mode are taken at the start of
// each number; writes made in the middle of a number apply to the next one.
// ----------------------------------------------------------------------------
module string_to_integer_parser #(
  parameter int COUNT_WIDTH = srtoi_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // character input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [srtoi_pkg::CHAR_WIDTH-1:0]     ch,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [srtoi_pkg::VALUE_WIDTH-1:0]    value,
  output logic [srtoi_pkg::CONSUMED_WIDTH-1:0] consumed,
  output logic                                 found,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srtoi_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [srtoi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [srtoi_pkg::BASE_WIDTH-1:0] number_base;
  logic                             signed_mode;
  logic                             in_full;
  logic [srtoi_pkg::CHAR_WIDTH-1:0] ch_reg;
  logic                             step;
  srtoi_pkg::char_class_t           cls;
  srtoi_pkg::result_t               res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= srtoi_pkg::BASE_AUTO;
      signed_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srtoi_pkg::REG_NUMBER_BASE: number_base <= cfg_data[srtoi_pkg::BASE_WIDTH-1:0];
        srtoi_pkg::REG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the step runs when a character waits and the result slot can take a word
  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_reg <= ch;
    end
  end

  srtoi_decode u_decode (
    .ch  (ch_reg),
    .cls (cls)
  );

  srtoi_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (step),
    .cls         (cls),
    .number_base (number_base),
    .signed_mode (signed_mode),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      value    <= res.value;
      consumed <= res.consumed;
      found    <= res.found;
    end
  end

  // a result without digits carries zero value and count
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> value == '0 && consumed == '0)
    else $error("empty result with nonzero value or count");

  // an empty input stage always takes a word
  assert property (@(posedge clk) disable iff (rst)
    !in_full |-> in_ready)
    else $error("input stage empty but not ready");

  // no result word is offered right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ----- hw/rtl/srtoi_decode.sv -----
// ----------------------------------------------------------------------------
// srtoi_decode
// Character classifier: white space, signs, hex prefix letter and digit value.
// ----------------------------------------------------------------------------
module srtoi_decode (
  input  logic [srtoi_pkg::CHAR_WIDTH-1:0] ch,
  output srtoi_pkg::char_class_t           cls
);

  // white space, signs, zero and the hex prefix letter
  always_comb begin
    cls.is_space = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0A) ||
                   (ch == 8'h0D) || (ch == 8'h0C) || (ch == 8'h0B);
    cls.is_plus  = (ch == 8'h2B);
    cls.is_minus = (ch == 8'h2D);
    cls.is_zero  = (ch == 8'h30);
    cls.is_x     = (ch == 8'h78) || (ch == 8'h58);
  end

  // digit value for 0-9, a-f, A-F
  always_comb begin
    cls.dig_ok = 1'b0;
    cls.dig    = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      cls.dig_ok = 1'b1;
      cls.dig    = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      cls.dig_ok = 1'b1;
      cls.dig    = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      cls.dig_ok = 1'b1;
      cls.dig    = 4'(ch - 8'h37);
    end
  end

endmodule

// ----- hw/rtl/srtoi_core.sv -----
// ----------------------------------------------------------------------------
// srtoi_core
// Parse state registers and the per-character step: sign, prefix, one
// multiply-add on the accumulator, and the result when the number ends.
// ----------------------------------------------------------------------------
module srtoi_core #(
  parameter int COUNT_WIDTH = srtoi_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  srtoi_pkg::char_class_t           cls,
  input  logic [srtoi_pkg::BASE_WIDTH-1:0] number_base,
  input  logic                             signed_mode,
  output srtoi_pkg::result_t               res
);

  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_HEXPFX = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  localparam int VW   = srtoi_pkg::VALUE_WIDTH;
  localparam int BW   = srtoi_pkg::BASE_WIDTH;
  localparam int CNW  = srtoi_pkg::CONSUMED_WIDTH;
  localparam int EXTW = COUNT_WIDTH + CNW;

  logic [2:0]             phase, phase_next;
  logic                   minus_seen, minus_seen_next;
  logic [VW-1:0]          accumulator, accumulator_next;
  logic [BW-1:0]          active_base, active_base_next;
  logic [COUNT_WIDTH-1:0] char_count, char_count_next;
  logic                   digit_seen, digit_seen_next;

  logic                   begin_zero;
  logic [BW-1:0]          begin_base;
  logic [BW-1:0]          zero_base;
  logic                   take;
  logic [BW-1:0]          take_base;
  logic [COUNT_WIDTH-1:0] take_cnt;
  logic                   finish;
  logic [VW+BW-1:0]       prod;
  logic [EXTW-1:0]        cnt_ext;

  // saturating increment of the character counter
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, c} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    sat_inc = s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  // radix choices at the start of a number and after a leading zero
  assign begin_zero = ((number_base == srtoi_pkg::BASE_AUTO) ||
                       (number_base == srtoi_pkg::BASE_HEX)) && cls.is_zero;
  assign begin_base = (number_base == srtoi_pkg::BASE_AUTO) ? srtoi_pkg::BASE_DEC
                                                             : number_base;
  assign zero_base  = (active_base == srtoi_pkg::BASE_AUTO) ? srtoi_pkg::BASE_OCT
                                                             : srtoi_pkg::BASE_HEX;

  // next state and result
  always_comb begin
    phase_next       = phase;
    minus_seen_next  = minus_seen;
    accumulator_next = accumulator;
    active_base_next = active_base;
    char_count_next  = char_count;
    digit_seen_next  = digit_seen;
    take             = 1'b0;
    take_base        = active_base;
    take_cnt         = char_count;
    finish           = 1'b0;

    case (phase)
      PH_SKIP, PH_START: begin
        if (phase == PH_SKIP && cls.is_space) begin
          char_count_next = sat_inc(char_count);
        end else if (phase == PH_SKIP && (cls.is_plus || (cls.is_minus && signed_mode))) begin
          minus_seen_next = cls.is_minus;
          char_count_next = sat_inc(char_count);
          phase_next      = PH_START;
        end else if (begin_zero) begin
          active_base_next = number_base;
          accumulator_next = '0;
          digit_seen_next  = 1'b1;
          char_count_next  = sat_inc(char_count);
          phase_next       = PH_ZERO;
        end else begin
          take             = 1'b1;
          take_base        = begin_base;
          active_base_next = begin_base;
        end
      end
      PH_ZERO: begin
        if (cls.is_x) begin
          phase_next = PH_HEXPFX;
        end else begin
          take             = 1'b1;
          take_base        = zero_base;
          active_base_next = zero_base;
        end
      end
      PH_HEXPFX: begin
        if (cls.dig_ok) begin
          // the prefix letter counts only when a hex digit follows
          take             = 1'b1;
          take_base        = srtoi_pkg::BASE_HEX;
          active_base_next = srtoi_pkg::BASE_HEX;
          take_cnt         = sat_inc(char_count);
        end else begin
          finish = 1'b1;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        phase_next       = PH_SKIP;
        minus_seen_next  = 1'b0;
        accumulator_next = '0;
        active_base_next = '0;
        char_count_next  = '0;
        digit_seen_next  = 1'b0;
      end
    endcase

    // digit accumulate, or end of number
    prod = accumulator * take_base;
    if (take) begin
      if (cls.dig_ok && ({1'b0, cls.dig} < take_base)) begin
        accumulator_next = prod[VW-1:0] + VW'(cls.dig);
        digit_seen_next  = 1'b1;
        char_count_next  = sat_inc(take_cnt);
        phase_next       = PH_DIGITS;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      phase_next       = PH_SKIP;
      minus_seen_next  = 1'b0;
      accumulator_next = '0;
      active_base_next = '0;
      char_count_next  = '0;
      digit_seen_next  = 1'b0;
    end
  end

  // result word
  assign cnt_ext      = EXTW'(char_count);
  assign res.emit     = finish;
  assign res.found    = digit_seen;
  assign res.value    = !digit_seen ? '0 :
                        (minus_seen ? (VW'(0) - accumulator) : accumulator);
  assign res.consumed = digit_seen ? cnt_ext[CNW-1:0] : '0;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      minus_seen  <= 1'b0;
      accumulator <= '0;
      active_base <= '0;
      char_count  <= '0;
      digit_seen  <= 1'b0;
    end else if (en) begin
      phase       <= phase_next;
      minus_seen  <= minus_seen_next;
      accumulator <= accumulator_next;
      active_base <= active_base_next;
      char_count  <= char_count_next;
      digit_seen  <= digit_seen_next;
    end
  end

endmodule
